// ===== design/itp_pkg.sv =====
// Shared types and constants for the integer text parser.
// The controller and the datapath both use this package; it depends on nothing else.
`default_nettype none

package itp_pkg;

    // Fixed field widths.
    localparam int CHAR_WIDTH   = 8;
    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;
    localparam int STATUS_WIDTH = 2;
    localparam int RADIX_WIDTH  = 6;

    // Radix limits and fixed radixes.
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_TEN   = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_EIGHT = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_WIDTH-1:0] RADIX_ONE   = 6'd1;

    // Result status codes.
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_BADBASE = 2'd2;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;

    // Digit value given to a character that is no digit at all.
    localparam logic [RADIX_WIDTH-1:0] DIGIT_NONE = 6'd63;

    // Which radix the current request works under.
    typedef enum logic [1:0] {
        RSEL_KEEP  = 2'd0,
        RSEL_TEN   = 2'd1,
        RSEL_EIGHT = 2'd2,
        RSEL_HEX   = 2'd3
    } radix_sel_t;

    // What kind of result is loaded into the output register.
    typedef enum logic [1:0] {
        EMIT_VALUE   = 2'd0,
        EMIT_BADBASE = 2'd1
    } emit_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       step;
        logic       clear;
        logic       pos_inc;
        logic       load_sign;
        logic       take;
        logic       mark_taken;
        radix_sel_t radix_sel;
        logic       emit;
        emit_kind_t emit_kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_zero;
        logic base_invalid;
        logic radix_auto;
        logic radix_hex;
        logic is_space;
        logic is_sign;
        logic is_zero;
        logic is_x;
        logic lt_now;
        logic lt_ten;
        logic lt_eight;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/itp_datapath.sv =====
// Datapath of the integer text parser: base register, accumulator with
// multiply-add and overflow check, position counter and output payload.
// Depends on itp_pkg.
`default_nettype none

module itp_datapath #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [itp_pkg::RADIX_WIDTH-1:0]    number_base,
    input  wire logic [itp_pkg::CHAR_WIDTH-1:0]     char_code,
    input  wire itp_pkg::cmd_t                      cmd,
    output itp_pkg::stat_t                          stat,
    output logic [itp_pkg::VALUE_WIDTH-1:0]         parsed_value,
    output logic [itp_pkg::OFFSET_WIDTH-1:0]        end_offset,
    output logic [itp_pkg::STATUS_WIDTH-1:0]        status
);
    import itp_pkg::*;

    localparam int PROD_WIDTH = VALUE_WIDTH + RADIX_WIDTH;

    logic [RADIX_WIDTH-1:0]    base_reg;
    logic [RADIX_WIDTH-1:0]    eff_reg;
    logic [VALUE_WIDTH-1:0]    acc_reg;
    logic                      sat_reg;
    logic                      taken_reg;
    logic                      minus_reg;
    logic [POSITION_WIDTH-1:0] pos_reg;

    logic [VALUE_WIDTH-1:0]    value_reg;
    logic [OFFSET_WIDTH-1:0]   offset_reg;
    logic [STATUS_WIDTH-1:0]   status_reg;

    logic [RADIX_WIDTH-1:0]    radix_now;
    logic [RADIX_WIDTH-1:0]    radix_step;
    logic [RADIX_WIDTH-1:0]    radix_now_g;
    logic [RADIX_WIDTH-1:0]    radix_mul;
    logic [RADIX_WIDTH-1:0]    digit;
    logic [PROD_WIDTH-1:0]     prod;
    logic                      overflow;
    logic [31:0]               pos_wide;
    logic                      taken_now;

    // A radix outside 2..36 falls back to ten for digit tests.
    function automatic logic [RADIX_WIDTH-1:0] guard_radix(input logic [RADIX_WIDTH-1:0] r);
        logic bad;
        bad = (r < 6'd2) || (r > RADIX_MAX);
        return bad ? RADIX_TEN : r;
    endfunction

    // Digit value of a character, or the no-digit code.
    function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] t;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            t = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            t = c - CH_UA + 8'd10;
        end else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[RADIX_WIDTH-1:0];
    endfunction

    // The base register is sampled on the first character of each string.
    assign radix_now   = stat.pos_zero ? base_reg : eff_reg;
    assign radix_now_g = guard_radix(radix_now);
    assign digit       = digit_of(char_code);

    always_comb
    begin
        case (cmd.radix_sel)
            RSEL_TEN:   radix_step = RADIX_TEN;
            RSEL_EIGHT: radix_step = RADIX_EIGHT;
            RSEL_HEX:   radix_step = RADIX_HEX;
            default:    radix_step = radix_now;
        endcase
    end

    assign radix_mul = guard_radix(radix_step);

    // Status toward the controller.
    always_comb
    begin
        stat.pos_zero     = (pos_reg == '0);
        stat.base_invalid = (base_reg == RADIX_ONE) || (base_reg > RADIX_MAX);
        stat.radix_auto   = (radix_now == RADIX_AUTO);
        stat.radix_hex    = (radix_now == RADIX_HEX);
        stat.is_space     = (char_code == CH_SPACE) ||
                            ((char_code >= CH_TAB) && (char_code <= CH_CR));
        stat.is_sign      = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        stat.is_zero      = (char_code == CH_ZERO);
        stat.is_x         = (char_code == CH_LX) || (char_code == CH_UX);
        stat.lt_now       = (digit < radix_now_g);
        stat.lt_ten       = (digit < RADIX_TEN);
        stat.lt_eight     = (digit < RADIX_EIGHT);
    end

    // Multiply-add; any bit above the value width means overflow.
    assign prod     = acc_reg * radix_mul + {{VALUE_WIDTH{1'b0}}, digit};
    assign overflow = |prod[PROD_WIDTH-1:VALUE_WIDTH];

    // Base register written by the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg <= RADIX_AUTO;
        end else if (cfg_valid) begin
            base_reg <= number_base;
        end
    end

    // Per-string parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            eff_reg   <= RADIX_AUTO;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            taken_reg <= 1'b0;
            minus_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (cmd.step) begin
            if (cmd.clear) begin
                eff_reg   <= RADIX_AUTO;
                acc_reg   <= '0;
                sat_reg   <= 1'b0;
                taken_reg <= 1'b0;
                minus_reg <= 1'b0;
                pos_reg   <= '0;
            end else begin
                eff_reg <= radix_step;
                if (cmd.load_sign) begin
                    minus_reg <= (char_code == CH_MINUS);
                end
                if (cmd.mark_taken || cmd.take) begin
                    taken_reg <= 1'b1;
                end
                if (cmd.take && !sat_reg) begin
                    if (overflow) begin
                        sat_reg <= 1'b1;
                        acc_reg <= '1;
                    end else begin
                        acc_reg <= prod[VALUE_WIDTH-1:0];
                    end
                end
                if (cmd.pos_inc && (pos_reg != '1)) begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // End offset is the low bits of the position counter.
    always_comb
    begin
        pos_wide = '0;
        pos_wide[POSITION_WIDTH-1:0] = pos_reg;
    end

    assign taken_now = taken_reg || cmd.mark_taken;

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.step && cmd.emit) begin
            if (cmd.emit_kind == EMIT_BADBASE) begin
                value_reg  <= '0;
                offset_reg <= '0;
                status_reg <= STATUS_BADBASE;
            end else if (!taken_now) begin
                value_reg  <= '0;
                offset_reg <= '0;
                status_reg <= STATUS_OK;
            end else if (sat_reg) begin
                value_reg  <= '1;
                offset_reg <= pos_wide[OFFSET_WIDTH-1:0];
                status_reg <= STATUS_RANGE;
            end else begin
                value_reg  <= minus_reg ? ('0 - acc_reg) : acc_reg;
                offset_reg <= pos_wide[OFFSET_WIDTH-1:0];
                status_reg <= STATUS_OK;
            end
        end
    end

    assign parsed_value = value_reg;
    assign end_offset   = offset_reg;
    assign status       = status_reg;

    // A saturated accumulator holds all ones.
    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == '1))
        else $error("saturated accumulator is not all ones");

    // The accumulator moves only once a digit has been taken.
    a_acc_zero_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        !taken_reg |-> (acc_reg == '0))
        else $error("accumulator nonzero before any digit");

endmodule

`default_nettype wire

// ===== design/itp_controller.sv =====
// Controller of the integer text parser: parse phase state machine,
// output valid flag and input ready. Depends on itp_pkg.
`default_nettype none

module itp_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire itp_pkg::stat_t stat,
    output itp_pkg::cmd_t       cmd
);
    import itp_pkg::*;

    typedef enum logic [4:0] {
        ST_SKIP   = 5'b00001,
        ST_SIGN   = 5'b00010,
        ST_ZERO   = 5'b00100,
        ST_HEX    = 5'b01000,
        ST_DIGITS = 5'b10000
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   step;

    // A new character is taken whenever the output register is free or drains.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // Decode of one character against the current phase.
    always_comb
    begin
        logic first_char;
        logic digit_ok;
        first_char = 1'b0;
        digit_ok   = 1'b0;

        phase_next    = phase_reg;
        cmd           = '0;
        cmd.step      = step;
        cmd.radix_sel = RSEL_KEEP;
        cmd.emit_kind = EMIT_VALUE;

        if ((phase_reg == ST_SKIP) && stat.pos_zero && stat.base_invalid) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_BADBASE;
            cmd.clear     = 1'b1;
            phase_next    = ST_SKIP;
        end else begin
            unique case (phase_reg)
                ST_SKIP:
                begin
                    if (stat.is_space) begin
                        cmd.pos_inc = 1'b1;
                    end else if (stat.is_sign) begin
                        cmd.load_sign = 1'b1;
                        cmd.pos_inc   = 1'b1;
                        phase_next    = ST_SIGN;
                    end else begin
                        first_char = 1'b1;
                    end
                end
                ST_SIGN:
                begin
                    first_char = 1'b1;
                end
                ST_ZERO:
                begin
                    if (stat.is_x) begin
                        cmd.radix_sel = RSEL_HEX;
                        cmd.pos_inc   = 1'b1;
                        phase_next    = ST_HEX;
                    end else begin
                        cmd.radix_sel  = stat.radix_auto ? RSEL_EIGHT : RSEL_KEEP;
                        cmd.mark_taken = 1'b1;
                        phase_next     = ST_DIGITS;
                        digit_ok       = stat.radix_auto ? stat.lt_eight : stat.lt_now;
                    end
                end
                ST_HEX, ST_DIGITS:
                begin
                    phase_next = ST_DIGITS;
                    digit_ok   = stat.lt_now;
                end
                default:
                begin
                    phase_next = ST_SKIP;
                    cmd.clear  = 1'b1;
                end
            endcase

            // First character after white space and sign.
            if (first_char) begin
                if (stat.is_zero && (stat.radix_auto || stat.radix_hex)) begin
                    cmd.pos_inc = 1'b1;
                    phase_next  = ST_ZERO;
                end else begin
                    cmd.radix_sel = stat.radix_auto ? RSEL_TEN : RSEL_KEEP;
                    phase_next    = ST_DIGITS;
                    digit_ok      = stat.radix_auto ? stat.lt_ten : stat.lt_now;
                end
            end

            // Digit accepted or the string ends here.
            if (phase_next == ST_DIGITS) begin
                if (digit_ok) begin
                    cmd.take    = 1'b1;
                    cmd.pos_inc = 1'b1;
                end else begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = 1'b1;
                    phase_next = ST_SKIP;
                end
            end
        end

        if (!step) begin
            phase_next = phase_reg;
        end
    end

    // Output valid flag of the result register.
    always_comb
    begin
        if (step && cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= ST_SKIP;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Every result closes its string and returns to white space skipping.
    a_emit_back_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd.emit) |=> (phase_reg == ST_SKIP))
        else $error("phase did not return to skip after a result");

    // A result always loads the output register as valid.
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd.emit) |=> out_valid_reg)
        else $error("result produced without output valid");

endmodule

`default_nettype wire

// ===== design/integer_text_parser_unit.sv =====
// Integer text parser: streaming unsigned 64-bit parse of text characters.
// Top level; instantiates itp_controller and itp_datapath, uses itp_pkg.
//
// Usage:
//   Characters arrive one per request on in_valid/in_ready/char_code.
//   Each character is handled in the cycle it is accepted: white space,
//   sign, base prefix and digits update the parse state, and the first
//   character that is not accepted ends the string and loads one result
//   (parsed_value, end_offset, status) into the output register.
//   Results leave on out_valid/out_ready; out_valid rises in the cycle
//   after the ending character is taken. Throughput is one character per
//   cycle, set by the datapath's combinational 64-by-6-bit multiply-add.
//   When the receiver stalls with a result waiting, in_ready drops until
//   that result is taken; a character that ends no string is still taken
//   when the output register drains in the same cycle.
//   The base register is written over cfg_valid/cfg_ready/number_base,
//   which is always ready; it is sampled on the first character of a string.
//   Reset clears the base to automatic detection, the parse state and the
//   output valid flag; no clearing pass is needed.
`default_nettype none

module integer_text_parser_unit #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [itp_pkg::RADIX_WIDTH-1:0] number_base,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [itp_pkg::CHAR_WIDTH-1:0]  char_code,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [itp_pkg::VALUE_WIDTH-1:0]      parsed_value,
    output logic [itp_pkg::OFFSET_WIDTH-1:0]     end_offset,
    output logic [itp_pkg::STATUS_WIDTH-1:0]     status
);
    import itp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The base register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    itp_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    itp_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .number_base  (number_base),
        .char_code    (char_code),
        .cmd          (cmd),
        .stat         (stat),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .status       (status)
    );

endmodule

`default_nettype wire
